// ----- rtl/core/tscc_pkg.sv -----
`default_nettype none

package tscc_pkg;

  // Entries per stack.
  localparam int DEPTH = 16;
  // Bits to address an entry, and bits to hold a count from zero to DEPTH.
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;

  // Item kinds.
  localparam logic KIND_PUSH    = 1'b0;
  localparam logic KIND_COMPARE = 1'b1;

  // Push targets.
  localparam logic SEL_A = 1'b0;
  localparam logic SEL_B = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_PUSH_OK   = 2'd0,
    ST_PUSH_FULL = 2'd1,
    ST_COMPARE   = 2'd2
  } status_t;

  // Comparison sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_A,
    S_CAP_A,
    S_SCAN,
    S_DONE
  } state_t;

  // Occupancy of one stack, as seen by the sequencer.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             full;
  } stk_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/tscc_stack.sv -----
`default_nettype none

module tscc_stack (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  input  wire logic signed [tscc_pkg::VAL_W-1:0] push_value,
  input  wire logic [tscc_pkg::IDX_W-1:0]   rd_idx,
  output logic signed [tscc_pkg::VAL_W-1:0] rd_data,
  output tscc_pkg::stk_status_t             stat
);
  import tscc_pkg::*;

  logic signed [VAL_W-1:0] mem [DEPTH];
  logic [CNT_W-1:0]        count;
  logic                    full;

  assign full       = (count == CNT_W'(DEPTH));
  assign stat.count = count;
  assign stat.full  = full;

  // A push to a full stack is dropped; the caller reports the rejection.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push && !full) begin
      count <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[count[IDX_W-1:0]] <= push_value;
    end
    rd_data <= mem[rd_idx];
  end

endmodule

`default_nettype wire

// ----- rtl/core/two_stack_content_compare.sv -----
`default_nettype none

// Two bounded stacks of signed 32-bit values with an unordered content check.
// Items arrive on the item channel (kind, stack_select, value) under
// item_valid / item_stall; each item yields exactly one result transfer on the
// result channel (status, equal) under result_valid / result_stall.
// A push is taken and its result is registered at the next edge, so pushes
// run at one item per cycle while the receiver keeps up. A push to a
// full stack leaves the stack alone and reports the full status.
// A compare decides at once when a stack is empty or the counts differ;
// otherwise it walks stack A entry by entry and, for each entry, scans stack B
// through its single registered read port. A matching entry ends the scan
// early. Only one compare is in flight at a time. The result sits in an
// output register; while the receiver stalls it holds, and no new item is
// taken until that register can be loaded again.
// Synchronous reset empties both stacks and drops any pending result; stack
// contents are not cleared, as entries above a count are never read.
module two_stack_content_compare (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         item_valid,
  output logic                              item_stall,
  input  wire logic                         kind,
  input  wire logic                         stack_select,
  input  wire logic signed [tscc_pkg::VAL_W-1:0] value,
  output logic                              result_valid,
  input  wire logic                         result_stall,
  output tscc_pkg::status_t                 status,
  output logic                              equal
);
  import tscc_pkg::*;

  state_t                  state, state_next;
  logic [IDX_W-1:0]        i_idx, i_next;
  logic [IDX_W-1:0]        j_idx, j_next;
  logic                    res_equal, res_equal_next;
  logic signed [VAL_W-1:0] a_val;

  logic                    accept;
  logic                    out_free;
  logic                    push_a, push_b;
  logic                    load_push, load_cmp;
  status_t                 push_status;

  logic [IDX_W-1:0]        a_rd_idx, b_rd_idx;
  logic signed [VAL_W-1:0] a_rd_data, b_rd_data;
  stk_status_t             stat_a, stat_b;

  logic                    last_i, last_j;

  // The output register can take a new result when empty or being drained.
  assign out_free   = !result_valid || !result_stall;
  assign item_stall = !((state == S_IDLE) && out_free);
  assign accept     = item_valid && !item_stall;

  assign push_a = accept && (kind == KIND_PUSH) && (stack_select == SEL_A);
  assign push_b = accept && (kind == KIND_PUSH) && (stack_select == SEL_B);

  tscc_stack u_stack_a (
    .clk        (clk),
    .rst        (rst),
    .push       (push_a),
    .push_value (value),
    .rd_idx     (a_rd_idx),
    .rd_data    (a_rd_data),
    .stat       (stat_a)
  );

  tscc_stack u_stack_b (
    .clk        (clk),
    .rst        (rst),
    .push       (push_b),
    .push_value (value),
    .rd_idx     (b_rd_idx),
    .rd_data    (b_rd_data),
    .stat       (stat_b)
  );

  // Both counts are equal throughout a walk, so either bounds both loops.
  assign last_i = ((CNT_W'(i_idx) + CNT_W'(1)) == stat_a.count);
  assign last_j = ((CNT_W'(j_idx) + CNT_W'(1)) == stat_b.count);

  always_comb begin
    state_next     = state;
    i_next         = i_idx;
    j_next         = j_idx;
    res_equal_next = res_equal;
    a_rd_idx       = i_idx;
    b_rd_idx       = '0;
    load_push      = 1'b0;
    load_cmp       = 1'b0;
    push_status    = ST_PUSH_OK;

    if (stack_select == SEL_A) begin
      push_status = stat_a.full ? ST_PUSH_FULL : ST_PUSH_OK;
    end else begin
      push_status = stat_b.full ? ST_PUSH_FULL : ST_PUSH_OK;
    end

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (kind == KIND_COMPARE) begin
            if ((stat_a.count == '0) && (stat_b.count == '0)) begin
              res_equal_next = 1'b1;
              state_next     = S_DONE;
            end else if (stat_a.count != stat_b.count) begin
              res_equal_next = 1'b0;
              state_next     = S_DONE;
            end else begin
              i_next     = '0;
              state_next = S_RD_A;
            end
          end else begin
            load_push = 1'b1;
          end
        end
      end
      S_RD_A: begin
        state_next = S_CAP_A;
      end
      S_CAP_A: begin
        // Entry A[i] arrives now; start the scan of B at its first entry.
        b_rd_idx   = '0;
        j_next     = '0;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        b_rd_idx = j_idx + IDX_W'(1);
        if (b_rd_data == a_val) begin
          if (last_i) begin
            res_equal_next = 1'b1;
            state_next     = S_DONE;
          end else begin
            i_next     = i_idx + IDX_W'(1);
            state_next = S_RD_A;
          end
        end else if (last_j) begin
          res_equal_next = 1'b0;
          state_next     = S_DONE;
        end else begin
          j_next = j_idx + IDX_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          load_cmp   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    i_idx     <= i_next;
    j_idx     <= j_next;
    res_equal <= res_equal_next;
    if (state == S_CAP_A) begin
      a_val <= a_rd_data;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_push || load_cmp) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_push) begin
      status <= push_status;
      equal  <= 1'b0;
    end else if (load_cmp) begin
      status <= ST_COMPARE;
      equal  <= res_equal;
    end
  end

  // Items are only taken while the sequencer is idle.
  assert property (@(posedge clk) disable iff (rst)
    accept |-> (state == S_IDLE))
    else $error("item taken while a compare is in progress");

  // Stack contents cannot change under a walk.
  assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |=> ($stable(stat_a.count) && $stable(stat_b.count)))
    else $error("stack count changed during a compare");

  // A push to full stack A leaves its count alone and reports the rejection.
  assert property (@(posedge clk) disable iff (rst)
    (push_a && stat_a.full) |=>
      ($stable(stat_a.count) && result_valid && (status == ST_PUSH_FULL)))
    else $error("push to full stack A not rejected");

  // A walk only starts on stacks of equal, non-zero size.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_RD_A) |-> ((stat_a.count == stat_b.count) && (stat_a.count != '0)))
    else $error("walk started on stacks of unequal or zero size");

  // Counts never exceed the stack depth.
  assert property (@(posedge clk) disable iff (rst)
    (stat_a.count <= CNT_W'(DEPTH)) && (stat_b.count <= CNT_W'(DEPTH)))
    else $error("stack count beyond depth");

endmodule

`default_nettype wire

// ----- bench/tscc_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of the stack compare block, keeps its own copy of the
// two stacks and checks every result transfer against the oldest outcome that
// is still awaited.
module tscc_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  input  logic                              item_stall,
  input  logic                              kind,
  input  logic                              stack_select,
  input  logic signed [tscc_pkg::VAL_W-1:0] value,
  input  logic                              result_valid,
  input  logic                              result_stall,
  input  tscc_pkg::status_t                 status,
  input  logic                              equal,
  output int                                fail_count,
  output int                                outstanding,
  output int                                results_checked,
  output int                                compares_equal,
  output int                                compares_unequal,
  output int                                pushes_rejected
);
  import tscc_pkg::*;

  typedef struct packed {
    status_t status;
    logic    equal;
  } outcome_t;

  logic [VAL_W-1:0] entries_a [DEPTH];
  logic [VAL_W-1:0] entries_b [DEPTH];
  int               fill_a;
  int               fill_b;
  outcome_t         awaited_outcomes [$];
  outcome_t         oldest;

  initial begin
    fail_count       = 0;
    outstanding      = 0;
    results_checked  = 0;
    compares_equal   = 0;
    compares_unequal = 0;
    pushes_rejected  = 0;
    fill_a           = 0;
    fill_b           = 0;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  // Unordered check: equal counts and every entry of A present somewhere in B.
  function automatic logic contents_match();
    logic found;
    if (fill_a == 0 && fill_b == 0)
      return 1'b1;
    if (fill_a != fill_b)
      return 1'b0;
    for (int i = 0; i < fill_a; i++) begin
      found = 1'b0;
      for (int j = 0; j < fill_b; j++)
        if (entries_b[j] == entries_a[i])
          found = 1'b1;
      if (!found)
        return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic outcome_t predict_outcome(input logic k, input logic s,
                                               input logic [VAL_W-1:0] v);
    outcome_t o;
    o.equal = 1'b0;
    if (k == KIND_COMPARE) begin
      o.status = ST_COMPARE;
      o.equal  = contents_match();
    end else if (s == SEL_A) begin
      if (fill_a >= DEPTH) begin
        o.status = ST_PUSH_FULL;
      end else begin
        entries_a[fill_a] = v;
        fill_a++;
        o.status = ST_PUSH_OK;
      end
    end else begin
      if (fill_b >= DEPTH) begin
        o.status = ST_PUSH_FULL;
      end else begin
        entries_b[fill_b] = v;
        fill_b++;
        o.status = ST_PUSH_OK;
      end
    end
    return o;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall)
        awaited_outcomes.push_back(predict_outcome(kind, stack_select, value));
      if (result_valid && !result_stall) begin
        if (awaited_outcomes.size() == 0) begin
          report_mismatch($sformatf("unexpected result transfer, status %0d equal %0b",
                                    status, equal));
        end else begin
          oldest = awaited_outcomes.pop_front();
          results_checked++;
          if (status !== oldest.status)
            report_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                      results_checked, status, oldest.status));
          if (equal !== oldest.equal)
            report_mismatch($sformatf("result %0d: equal %0b, expected %0b",
                                      results_checked, equal, oldest.equal));
          if (oldest.status == ST_COMPARE && oldest.equal)
            compares_equal++;
          else if (oldest.status == ST_COMPARE)
            compares_unequal++;
          else if (oldest.status == ST_PUSH_FULL)
            pushes_rejected++;
        end
      end
      outstanding = awaited_outcomes.size();
    end
  end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

// Top of the bench for the two-stack content compare block. It makes the
// clock and the single reset, drives the item channel, plays the receiver on
// the result channel and gives the verdict. All prediction and checking lives
// in the checker module instantiated beside the block.
module tb_top;
  import tscc_pkg::*;

  // Items in the random part of the run, after the directed opening.
  localparam int NUM_RANDOM   = 1830;
  // The tail allows for a full compare walk.
  localparam int DRAIN_CYCLES = 400;
  // Watchdog limit, far above the slowest plausible run.
  localparam int CYCLE_LIMIT  = 4_000_000;

  logic                    clk;
  logic                    rst          = 1'b1;
  logic                    item_valid   = 1'b0;
  logic                    item_stall;
  logic                    kind         = KIND_PUSH;
  logic                    stack_select = SEL_A;
  logic signed [VAL_W-1:0] value        = '0;
  logic                    result_valid;
  logic                    result_stall = 1'b1;
  status_t                 status;
  logic                    equal;

  int fail_count;
  int outstanding;
  int results_checked;
  int compares_equal;
  int compares_unequal;
  int pushes_rejected;

  int cycles        = 0;
  int items_sent    = 0;
  int compares_sent = 0;
  // Pushes issued to each stack, saturating at the depth. Every issued item
  // is taken in order, so these track the fill of the block's stacks and are
  // used only to shape the stimulus.
  int issued_a      = 0;
  int issued_b      = 0;

  two_stack_content_compare i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .kind         (kind),
    .stack_select (stack_select),
    .value        (value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .equal        (equal)
  );

  tscc_checker i_check (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .kind             (kind),
    .stack_select     (stack_select),
    .value            (value),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .status           (status),
    .equal            (equal),
    .fail_count       (fail_count),
    .outstanding      (outstanding),
    .results_checked  (results_checked),
    .compares_equal   (compares_equal),
    .compares_unequal (compares_unequal),
    .pushes_rejected  (pushes_rejected)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung handshake or a result that never comes ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, outstanding);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Gap between transfers on the item channel: mostly none or short, now and
  // then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50)
      return 0;
    else if (r < 85)
      return $urandom_range(1, 3);
    else
      return $urandom_range(5, 40);
  endfunction

  // Values for pushes. A small pool of repeating values makes matches between
  // the stacks likely; the rest are fully random words.
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -32'sd1;
      4, 5:    return 32'sd7;
      6:       return 32'sd42;
      default: return $urandom();
    endcase
  endfunction

  // Offers one item from a falling edge and holds it until the transfer is
  // taken. It returns at a falling edge, after any gap that follows. When no
  // gap follows, valid simply stays high into the next item.
  task automatic send_item(input logic k, input logic s,
                           input logic signed [VAL_W-1:0] v, input int gap);
    kind         <= k;
    stack_select <= s;
    value        <= v;
    item_valid   <= 1'b1;
    do @(posedge clk); while (item_stall);
    items_sent++;
    if (k == KIND_COMPARE)
      compares_sent++;
    else if (s == SEL_A && issued_a < DEPTH)
      issued_a++;
    else if (s == SEL_B && issued_b < DEPTH)
      issued_b++;
    @(negedge clk);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Receiver. Right after reset it holds off for a long stretch while the
  // directed items keep coming, so the output register fills and the block
  // has to stall its input. After that it stalls in random bursts, with
  // stall-free stretches of random length in between.
  initial begin
    int r;
    int len;
    do @(negedge clk); while (rst);
    result_stall <= 1'b1;
    repeat (120) @(negedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        result_stall <= 1'b0;
        len = $urandom_range(1, 40);
      end else if (r < 88) begin
        result_stall <= 1'b1;
        len = $urandom_range(1, 3);
      end else begin
        result_stall <= 1'b1;
        len = $urandom_range(10, 60);
      end
      repeat (len) @(negedge clk);
    end
  end

  // Stimulus and verdict.
  initial begin
    logic                    k;
    logic                    s;
    logic signed [VAL_W-1:0] v;
    int                      gap;

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed opening. Stacks never shrink and there is only one reset, so
    // the order matters: each compare below sees the state built so far.
    // Both stacks empty must compare equal.
    send_item(KIND_COMPARE, SEL_A, '0, 0);
    // One stack empty, the other not: size mismatch.
    send_item(KIND_PUSH, SEL_A, 32'sh8000_0000, 0);
    send_item(KIND_COMPARE, SEL_A, '0, 0);
    // Same size but different content.
    send_item(KIND_PUSH, SEL_B, 32'sh7fff_ffff, 0);
    send_item(KIND_COMPARE, SEL_B, '0, 1);
    // Same content in a different order is equal.
    send_item(KIND_PUSH, SEL_A, 32'sh7fff_ffff, 0);
    send_item(KIND_PUSH, SEL_B, 32'sh8000_0000, 0);
    send_item(KIND_COMPARE, SEL_A, '0, 0);
    // Duplicates are not counted: A holds 1 twice, B holds 1 and 2, and the
    // stacks still compare equal.
    send_item(KIND_PUSH, SEL_A, 32'sd1, 0);
    send_item(KIND_PUSH, SEL_A, 32'sd1, 0);
    send_item(KIND_PUSH, SEL_B, 32'sd1, 0);
    send_item(KIND_PUSH, SEL_B, 32'sd2, 2);
    send_item(KIND_COMPARE, SEL_A, '0, 0);
    // All-zero and all-one words; the fields of a compare are ignored, so
    // these compares carry selects and values that must make no difference.
    send_item(KIND_PUSH, SEL_A, '0, 0);
    send_item(KIND_PUSH, SEL_B, -32'sd1, 0);
    send_item(KIND_COMPARE, SEL_B, -32'sd1, 0);
    send_item(KIND_COMPARE, SEL_A, 32'sh5a5a_a5a5, 3);

    // Random part. While the stacks still have room most items are pushes,
    // steered towards the emptier stack so that counts often agree and the
    // compares do real walks. Once both are full, pushes are rejected and
    // compares walk the full stacks.
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (issued_a < DEPTH || issued_b < DEPTH)
        k = ($urandom_range(0, 99) < 70) ? KIND_PUSH : KIND_COMPARE;
      else
        k = ($urandom_range(0, 99) < 40) ? KIND_PUSH : KIND_COMPARE;
      s = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 75) begin
        if (issued_a < issued_b)
          s = SEL_A;
        else if (issued_b < issued_a)
          s = SEL_B;
      end
      v = pick_value();
      // Every few hundred items a stretch runs back to back with no gaps.
      gap = (i % 250 < 40) ? 0 : pick_gap();
      send_item(k, s, v, gap);
    end
    item_valid <= 1'b0;

    // Drain: wait for every awaited result, then let a full compare's worth
    // of cycles pass so that any stray transfer is still seen.
    while (outstanding != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d items (%0d compares); checked %0d result transfers.",
             items_sent, compares_sent, results_checked);
    $display("Compares judged equal %0d, unequal %0d; pushes refused on a full stack %0d.",
             compares_equal, compares_unequal, pushes_rejected);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/tscc_pkg.sv
rtl/core/tscc_stack.sv
rtl/core/two_stack_content_compare.sv
bench/tscc_checker.sv
bench/tb_top.sv
